// File: src/object_slot_table_assert.svh
// assertion macros used by the checker of the object slot table
`ifndef OBJECT_SLOT_TABLE_ASSERT_SVH
`define OBJECT_SLOT_TABLE_ASSERT_SVH

// same-cycle implication
`define OST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("object slot table check failed");

// next-cycle implication
`define OST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("object slot table check failed");

`endif

// File: src/ost_pkg.sv
package ost_pkg;

   localparam int FIELD_W        = 32;
   localparam int ENTRY_ID_LSB   = 32;
   localparam int ENTRY_SLOT_LSB = 64;

   typedef enum logic [2:0] {
      REQ_INSERT     = 3'd0,
      REQ_DELETE     = 3'd1,
      REQ_LOOKUP     = 3'd2,
      REQ_SET_FLAGS  = 3'd3,
      REQ_READ_ORDER = 3'd4
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FAIL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SEL_RANK = 2'd0,
      SEL_SLOT = 2'd1,
      SEL_ID   = 2'd2
   } sel_mode_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_EVAL   = 2'd1,
      S_UPDATE = 2'd2
   } state_type;

   typedef struct packed {
      sel_mode_type        sel_mode;
      logic [FIELD_W-1:0]  key_id;
      logic                upd_en;
   } cell_ctrl_type;

endpackage

// File: src/object_slot_table.sv
// Object slot table: SLOTS slots of {id, flags}, flags of zero marking a free slot.
// Request channel req_valid/req_stall carries req_type, req_obj_id, req_obj_flags
// and req_slot_index; every request gives exactly one item on the rsp_ channel.
// The slots live in a chain of cells kept in rank order: occupied slots by
// ascending id (equal ids by slot), then free slots by slot. Lookup, rank read,
// slot addressing and lowest-free-slot all come from one compare in every cell.
// A request is registered on acceptance and evaluated in the evaluate state, where the
// result register loads unless a held result blocks it; req_stall is high there, so
// a new request waits until the last is evaluated. A slot-changing request shifts the
// chain in the update state, in the same cycle in which the next request can be taken.
// Stall: a result held by rsp_stall stays unchanged; one more request is taken
// and waits, evaluated, until the result register frees; req_stall stays high
// meanwhile.
// Reset: every slot free, occupied count zero, rank order equal to slot order.
// No clearing pass; requests are accepted in the first cycle after reset.
module object_slot_table #(
   parameter int SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_obj_id,
   input  logic [31:0] req_obj_flags,
   input  logic [4:0]  req_slot_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_slot_out,
   output logic [31:0] rsp_id_out,
   output logic [31:0] rsp_flags_out,
   output logic [5:0]  rsp_occupied_count
);
   import ost_pkg::*;

   localparam int SW = $clog2(SLOTS);
   localparam int NW = $clog2(SLOTS + 1);
   localparam int EW = SW + 65;
   localparam int CW = ((SW > 5) ? SW : 5) + 1;
   localparam int OW = (NW > 6) ? NW : 6;

   state_type          state_ff, state_in;
   logic [2:0]         kind_ff;
   logic [FIELD_W-1:0] obj_id_ff;
   logic [FIELD_W-1:0] obj_flags_ff;
   logic [4:0]         idx_ff;
   logic [NW-1:0]      count_ff, count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic [4:0]         rsp_slot_ff;
   logic [FIELD_W-1:0] rsp_id_ff;
   logic [FIELD_W-1:0] rsp_flags_ff;
   logic [5:0]         rsp_count_ff;

   logic [EW-1:0]      upd_old_ff;
   logic [EW-1:0]      upd_new_ff;

   logic               accept;
   logic               commit;
   logic               change;
   status_type         res_status;
   logic [4:0]         res_slot;
   logic [FIELD_W-1:0] res_id;
   logic [FIELD_W-1:0] res_flags;
   logic [NW-1:0]      cnt_nx;
   logic               new_valid;
   logic [FIELD_W-1:0] new_id;
   logic [FIELD_W-1:0] new_flags;
   logic [EW-1:0]      new_entry_c;

   cell_ctrl_type      ctrl;
   sel_mode_type       sel_mode_c;
   logic [SW-1:0]      sel_rank_c;
   logic [SW-1:0]      sel_slot_c;
   logic [CW-1:0]      idx_ext;
   logic               idx_ok;
   logic [CW-1:0]      slot_ext;
   logic [OW-1:0]      cnt_ext;

   logic [EW-1:0]      cur_entry [SLOTS];
   logic [EW-1:0]      cmp_entry [SLOTS];
   logic               cur_lt [SLOTS];
   logic               cmp_lt [SLOTS];
   logic               id_hit [SLOTS];
   logic               sel_hit [SLOTS];

   logic [EW-1:0]      sel_entry;
   logic               sel_any;
   logic               sel_valid;
   logic [SW-1:0]      sel_slot;
   logic [FIELD_W-1:0] sel_id;
   logic [FIELD_W-1:0] sel_flags;

   // ---------------- cell chain ----------------
   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      logic [EW-1:0] prv_e;
      logic          prv_l;
      logic          prv_h;
      logic [EW-1:0] nxt_e;
      logic          nxt_l;

      if (k == 0) begin : g_head
         assign prv_e = '0;
         assign prv_l = 1'b1;
         assign prv_h = 1'b0;
      end else begin : g_link_prv
         assign prv_e = cmp_entry[k-1];
         assign prv_l = cmp_lt[k-1];
         assign prv_h = id_hit[k-1];
      end

      if (k == SLOTS - 1) begin : g_tail
         assign nxt_e = '0;
         assign nxt_l = 1'b0;
      end else begin : g_link_nxt
         assign nxt_e = cur_entry[k+1];
         assign nxt_l = cur_lt[k+1];
      end

      ost_cell #(
         .SLOTS (SLOTS),
         .POS   (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .sel_slot   (sel_slot_c),
         .sel_rank   (sel_rank_c),
         .old_entry  (upd_old_ff),
         .new_entry  (upd_new_ff),
         .prv_entry  (prv_e),
         .prv_lt     (prv_l),
         .prv_id_hit (prv_h),
         .nxt_entry  (nxt_e),
         .nxt_lt     (nxt_l),
         .cur_entry  (cur_entry[k]),
         .cur_lt     (cur_lt[k]),
         .cmp_entry  (cmp_entry[k]),
         .cmp_lt     (cmp_lt[k]),
         .id_hit     (id_hit[k]),
         .sel_hit    (sel_hit[k])
      );
   end

   // one-hot pick of the addressed cell
   always_comb begin
      sel_entry = '0;
      sel_any   = 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
         if (sel_hit[k]) begin
            sel_entry = sel_entry | cur_entry[k];
            sel_any   = 1'b1;
         end
      end
   end

   assign sel_valid = sel_entry[EW-1];
   assign sel_slot  = sel_entry[ENTRY_SLOT_LSB +: SW];
   assign sel_id    = sel_entry[ENTRY_ID_LSB +: FIELD_W];
   assign sel_flags = sel_entry[0 +: FIELD_W];

   // ---------------- addressing ----------------
   assign idx_ext    = CW'(idx_ff);
   assign idx_ok     = idx_ext < CW'(SLOTS);
   assign sel_slot_c = idx_ext[SW-1:0];
   assign slot_ext   = CW'(sel_slot);

   always_comb begin
      unique case (kind_ff) inside
         REQ_INSERT, REQ_READ_ORDER: sel_mode_c = SEL_RANK;
         REQ_DELETE, REQ_SET_FLAGS:  sel_mode_c = SEL_SLOT;
         default:                    sel_mode_c = SEL_ID;
      endcase
   end

   // insert takes the first free slot, which sits at rank count
   assign sel_rank_c = (kind_ff == REQ_INSERT) ? SW'(count_ff) : idx_ext[SW-1:0];

   assign ctrl.sel_mode = sel_mode_c;
   assign ctrl.key_id   = obj_id_ff;
   assign ctrl.upd_en   = (state_ff == S_UPDATE);

   // ---------------- request evaluation ----------------
   always_comb begin
      res_status = ST_FAIL;
      res_slot   = '0;
      res_id     = '0;
      res_flags  = '0;
      change     = 1'b0;
      cnt_nx     = count_ff;
      new_valid  = 1'b0;
      new_id     = sel_id;
      new_flags  = '0;
      unique case (kind_ff)
         REQ_INSERT: begin
            if ((obj_flags_ff != '0) && (count_ff != NW'(SLOTS))) begin
               res_status = ST_OK;
               res_slot   = slot_ext[4:0];
               res_id     = obj_id_ff;
               res_flags  = obj_flags_ff;
               change     = 1'b1;
               new_valid  = 1'b1;
               new_id     = obj_id_ff;
               new_flags  = obj_flags_ff;
               cnt_nx     = count_ff + NW'(1);
            end
         end
         REQ_DELETE: begin
            if (idx_ok) begin
               res_status = ST_OK;
               res_slot   = slot_ext[4:0];
               if (sel_valid) begin
                  res_id = sel_id;
                  change = 1'b1;
                  cnt_nx = count_ff - NW'(1);
               end
            end
         end
         REQ_LOOKUP: begin
            res_status = ST_NOT_FOUND;
            if (sel_any) begin
               res_status = ST_OK;
               res_slot   = slot_ext[4:0];
               res_id     = sel_id;
               res_flags  = sel_flags;
            end
         end
         REQ_SET_FLAGS: begin
            if (idx_ok && sel_valid) begin
               res_status = ST_OK;
               res_slot   = slot_ext[4:0];
               res_id     = sel_id;
               res_flags  = obj_flags_ff;
               change     = 1'b1;
               new_valid  = (obj_flags_ff != '0);
               new_flags  = obj_flags_ff;
               if (obj_flags_ff == '0) begin
                  cnt_nx = count_ff - NW'(1);
               end
            end
         end
         REQ_READ_ORDER: begin
            if (idx_ok) begin
               res_status = ST_OK;
               res_slot   = slot_ext[4:0];
               if (sel_valid) begin
                  res_id    = sel_id;
                  res_flags = sel_flags;
               end
            end
         end
         default: begin
            res_status = ST_FAIL;
         end
      endcase
   end

   assign new_entry_c = {new_valid, sel_slot, new_id, new_flags};
   assign cnt_ext     = OW'(cnt_nx);

   // ---------------- control ----------------
   assign req_stall = !((state_ff == S_IDLE) || (state_ff == S_UPDATE));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      commit   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            commit = !rsp_valid_ff || !rsp_stall;
            if (commit) begin
               state_in = change ? S_UPDATE : S_IDLE;
            end
         end
         S_UPDATE: begin
            state_in = accept ? S_EVAL : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = commit || (rsp_valid_ff && rsp_stall);
   assign count_in     = commit ? cnt_nx : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff      <= req_type;
         obj_id_ff    <= req_obj_id;
         obj_flags_ff <= req_obj_flags;
         idx_ff       <= req_slot_index;
      end
      if (commit) begin
         rsp_status_ff <= res_status;
         rsp_slot_ff   <= res_slot;
         rsp_id_ff     <= res_id;
         rsp_flags_ff  <= res_flags;
         rsp_count_ff  <= cnt_ext[5:0];
         upd_old_ff    <= sel_entry;
         upd_new_ff    <= new_entry_c;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot_out       = rsp_slot_ff;
   assign rsp_id_out         = rsp_id_ff;
   assign rsp_flags_out      = rsp_flags_ff;
   assign rsp_occupied_count = rsp_count_ff;

endmodule

// File: src/ost_cell.sv
module ost_cell #(
   parameter int SLOTS = 32,
   parameter int POS   = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ost_pkg::cell_ctrl_type       ctrl,
   input  logic [$clog2(SLOTS)-1:0]     sel_slot,
   input  logic [$clog2(SLOTS)-1:0]     sel_rank,
   input  logic [$clog2(SLOTS)+64:0]    old_entry,
   input  logic [$clog2(SLOTS)+64:0]    new_entry,
   input  logic [$clog2(SLOTS)+64:0]    prv_entry,
   input  logic                         prv_lt,
   input  logic                         prv_id_hit,
   input  logic [$clog2(SLOTS)+64:0]    nxt_entry,
   input  logic                         nxt_lt,
   output logic [$clog2(SLOTS)+64:0]    cur_entry,
   output logic                         cur_lt,
   output logic [$clog2(SLOTS)+64:0]    cmp_entry,
   output logic                         cmp_lt,
   output logic                         id_hit,
   output logic                         sel_hit
);
   import ost_pkg::*;

   localparam int SW = $clog2(SLOTS);
   localparam int EW = SW + 65;
   localparam logic [SW-1:0] POS_CODE = SW'(POS);

   logic               valid_ff, valid_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic [FIELD_W-1:0] id_ff, id_in;
   logic [FIELD_W-1:0] flags_ff, flags_in;
   logic               ge_old;
   logic [EW-1:0]      next_entry;

   // occupied entries first by (id, slot), then free entries by slot
   function automatic logic key_lt(input logic [EW-1:0] a, input logic [EW-1:0] b);
      logic               a_valid, b_valid;
      logic [FIELD_W-1:0] a_id, b_id;
      logic [SW-1:0]      a_slot, b_slot;
      a_valid = a[EW-1];
      b_valid = b[EW-1];
      a_id    = a[ENTRY_ID_LSB +: FIELD_W];
      b_id    = b[ENTRY_ID_LSB +: FIELD_W];
      a_slot  = a[ENTRY_SLOT_LSB +: SW];
      b_slot  = b[ENTRY_SLOT_LSB +: SW];
      if (a_valid != b_valid) begin
         return a_valid;
      end else if (a_valid && (a_id != b_id)) begin
         return a_id < b_id;
      end else begin
         return a_slot < b_slot;
      end
   endfunction

   assign cur_entry = {valid_ff, slot_ff, id_ff, flags_ff};
   assign cur_lt    = key_lt(cur_entry, new_entry);
   assign ge_old    = !key_lt(cur_entry, old_entry);

   // view of this position once the old entry has been taken out
   assign cmp_entry = ge_old ? nxt_entry : cur_entry;
   assign cmp_lt    = ge_old ? nxt_lt : cur_lt;

   // put the new entry back in at its sorted place
   always_comb begin
      if (cmp_lt) begin
         next_entry = cmp_entry;
      end else if (prv_lt) begin
         next_entry = new_entry;
      end else begin
         next_entry = prv_entry;
      end
   end

   assign id_hit = valid_ff && (id_ff == ctrl.key_id);

   always_comb begin
      unique case (ctrl.sel_mode)
         SEL_RANK: sel_hit = (POS_CODE == sel_rank);
         SEL_SLOT: sel_hit = (slot_ff == sel_slot);
         SEL_ID:   sel_hit = id_hit && !prv_id_hit;
         default:  sel_hit = 1'b0;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      slot_in  = slot_ff;
      id_in    = id_ff;
      flags_in = flags_ff;
      if (ctrl.upd_en) begin
         valid_in = next_entry[EW-1];
         slot_in  = next_entry[ENTRY_SLOT_LSB +: SW];
         id_in    = next_entry[ENTRY_ID_LSB +: FIELD_W];
         flags_in = next_entry[0 +: FIELD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= POS_CODE;
      end else begin
         valid_ff <= valid_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      flags_ff <= flags_in;
   end

endmodule

// File: src/ost_checker.sv
`include "object_slot_table_assert.svh"

module ost_checker #(
   parameter int SLOTS = 32
) (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [4:0]  rsp_slot_out,
   input logic [31:0] rsp_id_out,
   input logic [31:0] rsp_flags_out,
   input logic [5:0]  rsp_occupied_count
);
   import ost_pkg::*;

   logic        rsp_held;
   logic        rsp_fail;
   logic        rsp_empty;
   logic        rsp_live;
   logic [76:0] rsp_payload;

   assign rsp_held    = rsp_valid && rsp_stall;
   assign rsp_payload = {rsp_status, rsp_slot_out, rsp_id_out, rsp_flags_out,
                         rsp_occupied_count};
   assign rsp_fail    = rsp_valid && (rsp_status != ST_OK);
   assign rsp_empty   = (rsp_slot_out == 5'd0) && (rsp_id_out == 32'd0) &&
                        (rsp_flags_out == 32'd0);
   assign rsp_live    = rsp_valid && (rsp_status == ST_OK) && (rsp_flags_out != 32'd0) &&
                        (SLOTS < 64);

   // a held result item does not move
   `OST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_payload))

   // failed requests carry an empty payload
   `OST_ASSERT_NOW(a_fail_zero, clock, reset, rsp_fail, rsp_empty)

   // a live object reported means the table is not empty
   `OST_ASSERT_NOW(a_live_count, clock, reset, rsp_live, rsp_occupied_count != 6'd0)

   // out of reset: nothing pending, ready for an item
   `OST_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && !req_stall)

endmodule

bind object_slot_table ost_checker #(.SLOTS(SLOTS)) u_ost_checker (.*);

// File: tb/tb_object_slot_table.sv
module tb_object_slot_table;
   import ost_pkg::*;

   localparam int SLOTS       = 32;
   localparam int HOLD_CYCLES = 80;
   localparam int STUCK_LIMIT = 2000;
   localparam int PHASE_ITEMS = 150;

   typedef struct {
      status_type  status;
      logic [4:0]  slot;
      logic [31:0] id;
      logic [31:0] flags;
      logic [5:0]  count;
   } table_result_type;

   // shadow copy of the table plus the queue of results still owed by the block
   class slot_table_scoreboard;
      bit [31:0]        flags[SLOTS];
      bit [31:0]        ids[SLOTS];
      int               rank[SLOTS];
      int               used;
      int               errors;
      int               requests;
      int               by_kind[8];
      int               full_refusals;
      int               lookup_misses;
      int               peak;
      table_result_type owed_q[$];

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            flags[i] = '0;
            ids[i]   = '0;
            rank[i]  = i;
         end
         used = 0;
         errors = 0;
         requests = 0;
         full_refusals = 0;
         lookup_misses = 0;
         peak = 0;
         for (int k = 0; k < 8; k++) by_kind[k] = 0;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      // occupied slots by ascending id (ties by slot), then free slots by slot
      function void reorder();
         int r;
         for (int i = 0; i < SLOTS; i++) begin
            r = 0;
            if (flags[i] != 0) begin
               for (int j = 0; j < SLOTS; j++)
                  if (flags[j] != 0 && (ids[j] < ids[i] || (ids[j] == ids[i] && j < i)))
                     r++;
            end else begin
               r = used;
               for (int j = 0; j < i; j++)
                  if (flags[j] == 0) r++;
            end
            if (r < SLOTS) rank[r] = i;
         end
      endfunction

      function void note_request(bit [2:0] kind, bit [31:0] id, bit [31:0] fl, bit [4:0] idx);
         table_result_type r;
         int               hit;
         int               s;
         r.status = ST_FAIL;
         r.slot   = '0;
         r.id     = '0;
         r.flags  = '0;
         hit      = SLOTS;
         case (kind)
            REQ_INSERT: begin
               if (fl != 0) begin
                  for (int j = SLOTS - 1; j >= 0; j--)
                     if (flags[j] == 0) hit = j;
                  if (hit < SLOTS) begin
                     flags[hit] = fl;
                     ids[hit]   = id;
                     used++;
                     reorder();
                     r.status = ST_OK;
                     r.slot   = 5'(hit);
                     r.id     = id;
                     r.flags  = fl;
                  end else begin
                     full_refusals++;
                  end
               end
            end
            REQ_DELETE: begin
               if (idx < SLOTS) begin
                  r.status = ST_OK;
                  r.slot   = idx;
                  // deleting a free slot changes nothing
                  if (flags[idx] != 0) begin
                     r.id = ids[idx];
                     flags[idx] = '0;
                     used--;
                     reorder();
                  end
               end
            end
            REQ_LOOKUP: begin
               r.status = ST_NOT_FOUND;
               for (int j = SLOTS - 1; j >= 0; j--)
                  if (flags[j] != 0 && ids[j] == id) hit = j;
               if (hit < SLOTS) begin
                  r.status = ST_OK;
                  r.slot   = 5'(hit);
                  r.id     = id;
                  r.flags  = flags[hit];
               end else begin
                  lookup_misses++;
               end
            end
            REQ_SET_FLAGS: begin
               if (idx < SLOTS && flags[idx] != 0) begin
                  r.status = ST_OK;
                  r.slot   = idx;
                  r.id     = ids[idx];
                  r.flags  = fl;
                  flags[idx] = fl;
                  if (fl == 0) begin
                     used--;
                     reorder();
                  end
               end
            end
            REQ_READ_ORDER: begin
               if (idx < SLOTS) begin
                  s = rank[idx];
                  r.status = ST_OK;
                  r.slot   = 5'(s);
                  if (flags[s] != 0) begin
                     r.id    = ids[s];
                     r.flags = flags[s];
                  end
               end
            end
            default: ;
         endcase
         r.count = 6'(used);
         if (used > peak) peak = used;
         requests++;
         by_kind[kind]++;
         owed_q.push_back(r);
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(table_result_type got);
         table_result_type want;
         if (owed_q.size() == 0) begin
            report("result item with nothing outstanding");
         end else begin
            want = owed_q.pop_front();
            if (got.status !== want.status)
               report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.slot !== want.slot)
               report($sformatf("slot_out got %0d want %0d", got.slot, want.slot));
            if (got.id !== want.id)
               report($sformatf("id_out got %h want %h", got.id, want.id));
            if (got.flags !== want.flags)
               report($sformatf("flags_out got %h want %h", got.flags, want.flags));
            if (got.count !== want.count)
               report($sformatf("occupied_count got %0d want %0d", got.count, want.count));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_type;
   logic [31:0] req_obj_id;
   logic [31:0] req_obj_flags;
   logic [4:0]  req_slot_index;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_slot_out;
   logic [31:0] rsp_id_out;
   logic [31:0] rsp_flags_out;
   logic [5:0]  rsp_occupied_count;

   slot_table_scoreboard sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_request  = 1'b0;
   bit filling       = 1'b1;
   int stuck         = 0;

   object_slot_table #(.SLOTS(SLOTS)) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_obj_id         (req_obj_id),
      .req_obj_flags      (req_obj_flags),
      .req_slot_index     (req_slot_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_slot_out       (rsp_slot_out),
      .rsp_id_out         (rsp_id_out),
      .rsp_flags_out      (rsp_flags_out),
      .rsp_occupied_count (rsp_occupied_count)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stall, or a long hold-off when asked
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      table_result_type got;
      bit               moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            got.status = status_type'(rsp_status);
            got.slot   = rsp_slot_out;
            got.id     = rsp_id_out;
            got.flags  = rsp_flags_out;
            got.count  = rsp_occupied_count;
            sb.check_result(got);
            moved = 1'b1;
         end
         if (req_valid && !req_stall) begin
            sb.note_request(req_type, req_obj_id, req_obj_flags, req_slot_index);
            moved = 1'b1;
         end
         stuck = moved ? 0 : stuck + 1;
         if (stuck >= STUCK_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STUCK_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input logic [2:0] kind, input logic [31:0] id,
                               input logic [31:0] fl, input logic [4:0] idx);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_type       = kind;
      req_obj_id     = id;
      req_obj_flags  = fl;
      req_slot_index = idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_request();
      int          p;
      int          hi;
      logic [2:0]  kind;
      logic [31:0] id;
      logic [31:0] fl;
      logic [4:0]  idx;
      // swing occupancy between nearly empty and full so both ends get exercised
      if (sb.used >= SLOTS && $urandom_range(0, 99) < 30) filling = 1'b0;
      if (sb.used <= 2) filling = 1'b1;
      p = $urandom_range(0, 99);
      if (filling)
         kind = (p < 45) ? REQ_INSERT : (p < 55) ? REQ_DELETE : (p < 70) ? REQ_LOOKUP :
                (p < 82) ? REQ_SET_FLAGS : (p < 97) ? REQ_READ_ORDER : 3'($urandom_range(5, 7));
      else
         kind = (p < 12) ? REQ_INSERT : (p < 52) ? REQ_DELETE : (p < 67) ? REQ_LOOKUP :
                (p < 82) ? REQ_SET_FLAGS : (p < 97) ? REQ_READ_ORDER : 3'($urandom_range(5, 7));
      // small id pool so lookups hit and equal ids tie in the order
      p = $urandom_range(0, 99);
      if (p < 70) id = $urandom_range(0, 7);
      else if (p < 80) id = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h8000_0000;
      else id = $urandom;
      p = $urandom_range(0, 99);
      if (kind == REQ_SET_FLAGS)
         fl = (p < 25) ? 32'h0 : $urandom;
      else
         fl = (p < 5) ? 32'h0 : (p < 15) ? 32'hFFFF_FFFF : $urandom;
      hi = sb.used + 2;
      if (hi > SLOTS - 1) hi = SLOTS - 1;
      if (kind != REQ_READ_ORDER && $urandom_range(0, 99) < 85)
         idx = 5'($urandom_range(0, hi));
      else
         idx = 5'($urandom_range(0, SLOTS - 1));
      send_request(kind, id, fl, idx);
   endtask

   initial begin
      sb             = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = '0;
      req_obj_id     = '0;
      req_obj_flags  = '0;
      req_slot_index = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 23;
      recv_idle_pct = 47;
      // empty table: free rank, delete of a free slot, missed lookup, zero-flag insert
      send_request(REQ_READ_ORDER, 32'h0, 32'h0, 5'd0);
      send_request(REQ_DELETE, 32'h0, 32'h0, 5'd31);
      send_request(REQ_LOOKUP, 32'h0, 32'h0, 5'd0);
      send_request(REQ_INSERT, 32'h1234_5678, 32'h0, 5'd0);
      send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
      send_request(REQ_INSERT, 32'h0, 32'h1, 5'd0);
      send_request(REQ_INSERT, 32'h5, 32'hA5A5_A5A5, 5'd0);
      send_request(REQ_INSERT, 32'h5, 32'h5A5A_5A5A, 5'd0);
      for (int r = 0; r < 5; r++)
         send_request(REQ_READ_ORDER, 32'h0, 32'h0, 5'(r));
      send_request(REQ_LOOKUP, 32'h5, 32'h0, 5'd0);
      send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0, 5'd0);
      send_request(REQ_SET_FLAGS, 32'h0, 32'h7, 5'd10);
      send_request(REQ_SET_FLAGS, 32'h0, 32'h8000_0000, 5'd2);
      // zero flags free the slot
      send_request(REQ_SET_FLAGS, 32'h0, 32'h0, 5'd2);
      send_request(REQ_DELETE, 32'h0, 32'h0, 5'd0);
      send_request(REQ_DELETE, 32'h0, 32'h0, 5'd0);
      send_request(REQ_INSERT, 32'h3, 32'h7, 5'd0);
      send_request(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
      send_request(3'd6, 32'h0, 32'h0, 5'd0);
      send_request(3'd7, 32'h0, 32'h1, 5'd1);
      send_request(REQ_READ_ORDER, 32'h0, 32'h0, 5'd31);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 23; recv_idle_pct = 47; end
            1: begin send_idle_pct = 47; recv_idle_pct = 23; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         // back up the result side so the block fills and stalls its input
         if (phase != 1) hold_request = 1'b1;
         repeat (PHASE_ITEMS) random_request();
      end
      req_valid = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("%0d requests: %0d insert, %0d delete, %0d lookup, %0d set-flags, %0d rank, %0d bad",
               sb.requests, sb.by_kind[0], sb.by_kind[1], sb.by_kind[2], sb.by_kind[3],
               sb.by_kind[4], sb.by_kind[5] + sb.by_kind[6] + sb.by_kind[7]);
      $display("inserts refused when full: %0d, missed lookups: %0d, peak occupancy %0d of %0d",
               sb.full_refusals, sb.lookup_misses, sb.peak, SLOTS);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/ost_pkg.sv
src/ost_cell.sv
src/object_slot_table.sv
src/ost_checker.sv
tb/tb_object_slot_table.sv
